### src/coverage_bin_range_monitor_top_macros.svh
// ---------------------------------------------------------------------------
// Coverage bin range monitor assertion macros
// Shared assertion forms for the monitor; they compile to nothing when SYNTH
// is defined.
// ---------------------------------------------------------------------------
`ifndef COVERAGE_BIN_RANGE_MONITOR_TOP_MACROS_SVH
`define COVERAGE_BIN_RANGE_MONITOR_TOP_MACROS_SVH
`ifndef SYNTH
`define CBRM_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("coverage monitor check failed");
`define CBRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("coverage monitor check failed");
`else
`define CBRM_ASSERT(label, ante, cons)
`define CBRM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/cbrm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Coverage bin range monitor package
// Constants, field layout and the token type that walks the bin chain.
// ---------------------------------------------------------------------------
package cbrm_pkg;

  localparam int unsigned DEF_MAX_BINS  = 16;
  localparam int unsigned DEF_HIT_WIDTH = 32;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned FIELD_W = 5;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned PCT_SCALE = 100;

  // Counts inside the chain are sized for tables of up to 511 bins.
  localparam int unsigned CNT_W = 9;
  localparam logic [CNT_W-1:0] CNT_ONE = 1;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

  localparam logic [KIND_W-1:0] KIND_NORMAL     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ILLEGAL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRANSITION = 2'd2;

  localparam logic ACTION_DEFINE = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;

  localparam int unsigned IN_LO_OFS   = 0;
  localparam int unsigned IN_HI_OFS   = 32;
  localparam int unsigned IN_KIND_OFS = 64;
  localparam int unsigned IN_VAL_OFS  = 66;
  localparam int unsigned IN_TDATA_W  = 104;

  localparam int unsigned OUT_TDATA_W = 56;

  typedef struct packed {
    logic              vld;
    logic              smp;
    logic              taken;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  matched;
    logic              illegal;
    logic [CNT_W-1:0]  newcov;
  } tok_t;

endpackage

### src/cbrm_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Coverage bin cell
// Holds one bin and updates the transaction token that passes through it.
// ---------------------------------------------------------------------------
`include "coverage_bin_range_monitor_top_macros.svh"

module cbrm_cell #(
  parameter int unsigned HIT_WIDTH = cbrm_pkg::DEF_HIT_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cbrm_pkg::tok_t tok_i,
  output cbrm_pkg::tok_t tok_o
);

  logic                          vld_q;
  logic [cbrm_pkg::DATA_W-1:0]   lo_q;
  logic [cbrm_pkg::DATA_W-1:0]   hi_q;
  logic [cbrm_pkg::KIND_W-1:0]   kind_q;
  logic [HIT_WIDTH-1:0]          hit_q;
  logic                          cov_q;
  cbrm_pkg::tok_t                tok_q;
  cbrm_pkg::tok_t                tok_d;
  logic                          in_range;
  logic                          hit;
  logic                          cap;

  always_comb begin
    in_range = !(tok_i.value < lo_q) && !(tok_i.value > hi_q);
    hit = tok_i.vld && tok_i.smp && vld_q && (kind_q != cbrm_pkg::KIND_TRANSITION)
          && in_range;
    cap = tok_i.vld && !tok_i.smp && !tok_i.taken && !vld_q;
    tok_d = tok_i;
    if (hit) begin
      tok_d.matched = tok_i.matched + cbrm_pkg::CNT_ONE;
      if (kind_q == cbrm_pkg::KIND_ILLEGAL) begin
        tok_d.illegal = 1'b1;
      end else if (!cov_q) begin
        tok_d.newcov = tok_i.newcov + cbrm_pkg::CNT_ONE;
      end
    end
    if (cap) begin
      tok_d.taken = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
      if (cap) begin
        vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      lo_q   <= tok_i.lo;
      hi_q   <= tok_i.hi;
      kind_q <= tok_i.kind;
      hit_q  <= '0;
      cov_q  <= 1'b0;
    end else if (hit) begin
      if (hit_q != {HIT_WIDTH{1'b1}}) begin
        hit_q <= hit_q + HIT_WIDTH'(1);
      end
      if (kind_q != cbrm_pkg::KIND_ILLEGAL) begin
        cov_q <= 1'b1;
      end
    end
  end

  assign tok_o = tok_q;

  `CBRM_ASSERT_NEXT(a_cell_keeps_bin, vld_q, vld_q)
  `CBRM_ASSERT(a_untaken_define_passes_full_cell, tok_q.vld && !tok_q.smp && !tok_q.taken, vld_q)
  `CBRM_ASSERT(a_sample_never_takes, tok_q.vld && tok_q.smp, !tok_q.taken)

endmodule

### src/coverage_bin_range_monitor_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Coverage bin range monitor
// Range-bin coverage table built as a chain of bin cells.
// ---------------------------------------------------------------------------
// Each accepted transaction becomes a token that walks the row of MAX_BINS bin
// cells, one cell per cycle; a define token is stored by the first empty cell
// and a sample token collects hits on its way. A seven-step shift-subtract
// divider then forms the coverage percentage before the result is loaded into
// the output register. The input takes one transaction at a time: it is ready
// again as soon as the previous result enters the output register, even while
// that result still waits to be taken; a later result that finds the output
// register still occupied waits in the done state until that register is free.
`include "coverage_bin_range_monitor_top_macros.svh"

module coverage_bin_range_monitor_top #(
  parameter int unsigned MAX_BINS  = cbrm_pkg::DEF_MAX_BINS,
  parameter int unsigned HIT_WIDTH = cbrm_pkg::DEF_HIT_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // bin_low, bin_high, bin_kind, sample_value, zero padding.
  input  logic [cbrm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // action.
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // matched_bins, illegal_hit, define_rejected, covered_bins, legal_bins,
  // coverage_percent, sample_total.
  output logic [cbrm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CW = $clog2(MAX_BINS + 1);
  localparam int unsigned RW = CW + cbrm_pkg::PCT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHAIN = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [2:0] DIV_FIRST = 3'd6;

  cbrm_pkg::tok_t tok [0:MAX_BINS];
  cbrm_pkg::tok_t head_tok;
  cbrm_pkg::tok_t end_tok;

  logic [1:0]                     state_q, state_d;
  logic [CW-1:0]                  defined_q, defined_d;
  logic [CW-1:0]                  legal_q, legal_d;
  logic [CW-1:0]                  covered_q, covered_d;
  logic [cbrm_pkg::DATA_W-1:0]    samples_q, samples_d;
  logic [CW-1:0]                  res_matched_q, res_matched_d;
  logic                           res_illegal_q, res_illegal_d;
  logic                           res_rejected_q, res_rejected_d;
  logic [RW-1:0]                  rem_q, rem_d;
  logic [cbrm_pkg::PCT_W-1:0]     quo_q, quo_d;
  logic [2:0]                     step_q, step_d;
  logic [RW-1:0]                  dsh;
  logic                           ge;
  logic                           accept;
  logic                           load;
  logic                           out_vld_q, out_vld_d;
  logic [cbrm_pkg::FIELD_W-1:0]   o_matched_q, o_covered_q, o_legal_q;
  logic                           o_illegal_q, o_rejected_q;
  logic [cbrm_pkg::PCT_W-1:0]     o_pct_q, pct_d;
  logic [cbrm_pkg::DATA_W-1:0]    o_total_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    head_tok       = '0;
    head_tok.vld   = accept;
    head_tok.smp   = (s_axis_tuser[0] == cbrm_pkg::ACTION_SAMPLE);
    head_tok.lo    = s_axis_tdata[cbrm_pkg::IN_LO_OFS +: cbrm_pkg::DATA_W];
    head_tok.hi    = s_axis_tdata[cbrm_pkg::IN_HI_OFS +: cbrm_pkg::DATA_W];
    head_tok.kind  = s_axis_tdata[cbrm_pkg::IN_KIND_OFS +: cbrm_pkg::KIND_W];
    head_tok.value = s_axis_tdata[cbrm_pkg::IN_VAL_OFS +: cbrm_pkg::DATA_W];
  end

  assign tok[0] = head_tok;

  for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
    cbrm_cell #(
      .HIT_WIDTH(HIT_WIDTH)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  assign end_tok = tok[MAX_BINS];

  assign dsh = RW'(legal_q) << step_q;
  assign ge  = (rem_q >= dsh);
  assign load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d        = state_q;
    defined_d      = defined_q;
    legal_d        = legal_q;
    covered_d      = covered_q;
    samples_d      = samples_q;
    res_matched_d  = res_matched_q;
    res_illegal_d  = res_illegal_q;
    res_rejected_d = res_rejected_q;
    rem_d          = rem_q;
    quo_d          = quo_q;
    step_d         = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CHAIN;
          if (s_axis_tuser[0] == cbrm_pkg::ACTION_SAMPLE &&
              samples_q != {cbrm_pkg::DATA_W{1'b1}}) begin
            samples_d = samples_q + cbrm_pkg::DATA_W'(1);
          end
        end
      end
      ST_CHAIN: begin
        if (end_tok.vld) begin
          if (end_tok.smp) begin
            covered_d      = covered_q + CW'(end_tok.newcov);
            res_matched_d  = CW'(end_tok.matched);
            res_illegal_d  = end_tok.illegal;
            res_rejected_d = 1'b0;
          end else begin
            res_matched_d  = '0;
            res_illegal_d  = 1'b0;
            res_rejected_d = !end_tok.taken;
            if (end_tok.taken) begin
              defined_d = defined_q + CW'(1);
              if (end_tok.kind != cbrm_pkg::KIND_ILLEGAL) begin
                legal_d = legal_q + CW'(1);
              end
            end
          end
          rem_d   = RW'(covered_d) * RW'(cbrm_pkg::PCT_SCALE);
          quo_d   = '0;
          step_d  = DIV_FIRST;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (ge) begin
          rem_d = rem_q - dsh;
        end
        quo_d = {quo_q[cbrm_pkg::PCT_W-2:0], ge};
        if (step_q == 3'd0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (defined_q == '0) begin
      pct_d = cbrm_pkg::PCT_NONE;
    end else if (legal_q == '0) begin
      pct_d = cbrm_pkg::PCT_FULL;
    end else begin
      pct_d = quo_q;
    end
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      defined_q <= '0;
      legal_q   <= '0;
      covered_q <= '0;
      samples_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      defined_q <= defined_d;
      legal_q   <= legal_d;
      covered_q <= covered_d;
      samples_q <= samples_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_matched_q  <= res_matched_d;
    res_illegal_q  <= res_illegal_d;
    res_rejected_q <= res_rejected_d;
    rem_q          <= rem_d;
    quo_q          <= quo_d;
    step_q         <= step_d;
    if (load) begin
      o_matched_q  <= cbrm_pkg::FIELD_W'(res_matched_q);
      o_illegal_q  <= res_illegal_q;
      o_rejected_q <= res_rejected_q;
      o_covered_q  <= cbrm_pkg::FIELD_W'(covered_q);
      o_legal_q    <= cbrm_pkg::FIELD_W'(legal_q);
      o_pct_q      <= pct_d;
      o_total_q    <= samples_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {o_total_q, o_pct_q, o_legal_q, o_covered_q,
                          o_rejected_q, o_illegal_q, o_matched_q};

  `CBRM_ASSERT_NEXT(a_accept_starts_walk, accept, state_q == ST_CHAIN)
  `CBRM_ASSERT(a_token_end_only_in_walk, end_tok.vld, state_q == ST_CHAIN)
  `CBRM_ASSERT(a_covered_within_legal, 1'b1, covered_q <= legal_q && legal_q <= defined_q)
  `CBRM_ASSERT(a_table_bound, 1'b1, defined_q <= CW'(MAX_BINS))
  `CBRM_ASSERT(a_pct_bound, out_vld_q, o_pct_q <= cbrm_pkg::PCT_FULL)

endmodule

### dv/tb_coverage_bin_range_monitor_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Coverage bin range monitor testbench
// Streams bin definitions and samples into the monitor with random gaps and
// back-pressure, predicts every report from a private copy of the bin table,
// and compares each report field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_coverage_bin_range_monitor_top;

  localparam int unsigned TABLE_SIZE   = cbrm_pkg::DEF_MAX_BINS;
  localparam logic [cbrm_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 730;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned PAD_W = cbrm_pkg::IN_TDATA_W - cbrm_pkg::IN_VAL_OFS
                                  - cbrm_pkg::DATA_W;

  typedef struct packed {
    logic [PAD_W-1:0]                    pad;
    logic [cbrm_pkg::DATA_W-1:0]         value;
    logic [cbrm_pkg::KIND_W-1:0]         kind;
    logic [cbrm_pkg::DATA_W-1:0]         hi;
    logic [cbrm_pkg::DATA_W-1:0]         lo;
  } bin_item_t;

  typedef struct packed {
    logic [cbrm_pkg::DATA_W-1:0]  total;
    logic [cbrm_pkg::PCT_W-1:0]   pct;
    logic [cbrm_pkg::FIELD_W-1:0] legal;
    logic [cbrm_pkg::FIELD_W-1:0] covered;
    logic                         rejected;
    logic                         illegal;
    logic [cbrm_pkg::FIELD_W-1:0] matched;
  } report_t;

  class coverage_scoreboard;
    logic [cbrm_pkg::DATA_W-1:0]        bin_lo      [TABLE_SIZE];
    logic [cbrm_pkg::DATA_W-1:0]        bin_hi      [TABLE_SIZE];
    logic [cbrm_pkg::KIND_W-1:0]        bin_kind    [TABLE_SIZE];
    logic [cbrm_pkg::DEF_HIT_WIDTH-1:0] hit_tally   [TABLE_SIZE];
    bit                                 bin_covered [TABLE_SIZE];
    int unsigned                        bins_defined;
    logic [cbrm_pkg::DATA_W-1:0]        samples_taken;
    report_t                            expected_reports [$];
    int unsigned                        mismatches;

    function new();
      bins_defined  = 0;
      samples_taken = '0;
      mismatches    = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_item(logic action, bin_item_t item);
      report_t     rep;
      int unsigned legal;
      int unsigned covered;
      rep     = '0;
      legal   = 0;
      covered = 0;
      if (action == cbrm_pkg::ACTION_DEFINE) begin
        if (bins_defined >= TABLE_SIZE) begin
          rep.rejected = 1'b1;
        end else begin
          bin_lo[bins_defined]      = item.lo;
          bin_hi[bins_defined]      = item.hi;
          bin_kind[bins_defined]    = item.kind;
          hit_tally[bins_defined]   = '0;
          bin_covered[bins_defined] = 1'b0;
          bins_defined++;
        end
      end else begin
        if (samples_taken != '1) samples_taken = samples_taken + cbrm_pkg::DATA_W'(1);
        for (int i = 0; i < bins_defined; i++) begin
          if (bin_kind[i] == cbrm_pkg::KIND_TRANSITION) continue;
          if (item.value < bin_lo[i] || item.value > bin_hi[i]) continue;
          rep.matched = rep.matched + cbrm_pkg::FIELD_W'(1);
          if (hit_tally[i] != '1) hit_tally[i] = hit_tally[i] + cbrm_pkg::DEF_HIT_WIDTH'(1);
          if (bin_kind[i] == cbrm_pkg::KIND_ILLEGAL) rep.illegal = 1'b1;
          else bin_covered[i] = 1'b1;
        end
      end
      for (int i = 0; i < bins_defined; i++) begin
        if (bin_kind[i] == cbrm_pkg::KIND_ILLEGAL) continue;
        legal++;
        if (bin_covered[i]) covered++;
      end
      rep.covered = cbrm_pkg::FIELD_W'(covered);
      rep.legal   = cbrm_pkg::FIELD_W'(legal);
      if (bins_defined == 0) rep.pct = cbrm_pkg::PCT_NONE;
      else if (legal == 0) rep.pct = cbrm_pkg::PCT_FULL;
      else rep.pct = cbrm_pkg::PCT_W'((covered * cbrm_pkg::PCT_SCALE) / legal);
      rep.total = samples_taken;
      expected_reports.push_back(rep);
    endfunction

    function void check_result(logic [cbrm_pkg::OUT_TDATA_W-1:0] data);
      report_t got;
      report_t want;
      got = report_t'(data);
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: report with no transaction pending, actual %h", $time, data);
        return;
      end
      want = expected_reports.pop_front();
      if (got.matched !== want.matched || got.illegal !== want.illegal ||
          got.rejected !== want.rejected || got.covered !== want.covered ||
          got.legal !== want.legal || got.pct !== want.pct || got.total !== want.total) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: report mismatch, fields matched/illegal/rejected/covered/legal/pct/total",
                   $time);
          $display("  expected %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                   want.matched, want.illegal, want.rejected, want.covered,
                   want.legal, want.pct, want.total);
          $display("  actual   %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                   got.matched, got.illegal, got.rejected, got.covered,
                   got.legal, got.pct, got.total);
        end
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [cbrm_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [0:0]                       s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [cbrm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  coverage_scoreboard report_board = new();
  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  bit hold_request = 1'b0;

  coverage_bin_range_monitor_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("TEST FAILED");
    $finish;
  end

  task automatic offer_item(input logic action, input logic [cbrm_pkg::DATA_W-1:0] lo,
                            input logic [cbrm_pkg::DATA_W-1:0] hi,
                            input logic [cbrm_pkg::KIND_W-1:0] kind,
                            input logic [cbrm_pkg::DATA_W-1:0] value);
    bin_item_t item;
    item.pad   = '0;
    item.value = value;
    item.kind  = kind;
    item.hi    = hi;
    item.lo    = lo;
    while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    s_axis_tuser  <= action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    report_board.note_item(action, item);
  endtask

  initial begin : report_sink
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) report_board.check_result(m_axis_tdata);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin : bin_stimulus
    logic [cbrm_pkg::DATA_W-1:0] lo;
    logic [cbrm_pkg::DATA_W-1:0] hi;
    logic [cbrm_pkg::DATA_W-1:0] value;
    logic [cbrm_pkg::KIND_W-1:0] kind;
    logic [63:0]                 span;
    int unsigned                 idx;
    int unsigned                 pick;
    int unsigned                 define_pct;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= cbrm_pkg::ACTION_DEFINE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, then a table that holds only an illegal bin.
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL,
               32'h0000_0000);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_ILLEGAL,
               32'hFFFF_FFFF);
    offer_item(cbrm_pkg::ACTION_DEFINE, 32'd100, 32'd200, cbrm_pkg::KIND_ILLEGAL, $urandom);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL, 32'd150);
    // Full range, transition, spare kind at the top value, inverted and single.
    offer_item(cbrm_pkg::ACTION_DEFINE, 32'h0000_0000, 32'hFFFF_FFFF, cbrm_pkg::KIND_NORMAL,
               $urandom);
    offer_item(cbrm_pkg::ACTION_DEFINE, 32'h0000_0000, 32'hFFFF_FFFF,
               cbrm_pkg::KIND_TRANSITION, $urandom);
    offer_item(cbrm_pkg::ACTION_DEFINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_SPARE, $urandom);
    offer_item(cbrm_pkg::ACTION_DEFINE, 32'd500, 32'd400, cbrm_pkg::KIND_NORMAL, $urandom);
    offer_item(cbrm_pkg::ACTION_DEFINE, 32'h0000_0000, 32'h0000_0000, cbrm_pkg::KIND_NORMAL,
               $urandom);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, KIND_SPARE, 32'h0000_0000);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL, 32'd450);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL,
               32'hFFFF_FFFF);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL, 32'd100);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL, 32'd200);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL, 32'd99);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL, 32'd201);
    offer_item(cbrm_pkg::ACTION_DEFINE, 32'h8000_0000, 32'hFFFF_FFFE, cbrm_pkg::KIND_NORMAL,
               $urandom);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL,
               32'h7FFF_FFFF);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL,
               32'h8000_0000);
    offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom, cbrm_pkg::KIND_NORMAL,
               32'hFFFF_FFFE);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_request = 1'b1;
      if (n == 400) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (report_board.pending() != 0);
      end
      tx_idle_on = !(n >= 450 && n < 600);
      rx_idle_on = tx_idle_on;
      define_pct = (report_board.bins_defined < TABLE_SIZE) ? 20 : 5;
      if ($urandom_range(0, 99) < define_pct) begin
        lo = $urandom;
        case ($urandom_range(0, 4))
          0: hi = lo;
          1: hi = lo + $urandom_range(1, 1000);
          2: hi = $urandom;
          3: hi = lo - $urandom_range(1, 1000);
          default: begin
            lo = $urandom_range(0, 255);
            hi = lo + $urandom_range(0, 64);
          end
        endcase
        pick = $urandom_range(0, 9);
        kind = (pick < 5) ? cbrm_pkg::KIND_NORMAL : (pick < 7) ? cbrm_pkg::KIND_ILLEGAL :
               (pick < 9) ? cbrm_pkg::KIND_TRANSITION : KIND_SPARE;
        offer_item(cbrm_pkg::ACTION_DEFINE, lo, hi, kind, $urandom);
      end else begin
        if (report_board.bins_defined != 0 && $urandom_range(0, 99) < 75) begin
          idx = $urandom_range(0, report_board.bins_defined - 1);
          lo  = report_board.bin_lo[idx];
          hi  = report_board.bin_hi[idx];
          case ($urandom_range(0, 4))
            0: value = lo;
            1: value = hi;
            2: value = lo - 1'b1;
            3: value = hi + 1'b1;
            default: begin
              span  = {32'd0, hi} - {32'd0, lo} + 64'd1;
              value = (hi >= lo) ? lo + cbrm_pkg::DATA_W'({32'd0, $urandom} % span) : lo;
            end
          endcase
        end else begin
          case ($urandom_range(0, 3))
            0: value = 32'h0000_0000;
            1: value = 32'hFFFF_FFFF;
            2: value = $urandom_range(0, 1023);
            default: value = $urandom;
          endcase
        end
        offer_item(cbrm_pkg::ACTION_SAMPLE, $urandom, $urandom,
                   cbrm_pkg::KIND_W'($urandom_range(0, 3)), value);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (report_board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (report_board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
